FILE: src/atts_pkg.sv
package atts_pkg;

  // Transaction codes of the input channel
  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_ZERO  = 2'd1,
    FUNC_POWER = 2'd2
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_STEPPING  = 2'd0,
    STATUS_CONVERGED = 2'd1,
    STATUS_FAILED    = 2'd2
  } status_t;

  // Configuration register indexes
  localparam logic CFG_TARGET_LEVEL = 1'b0;
  localparam logic CFG_MAX_TRIES    = 1'b1;

  localparam logic [15:0] DEFAULT_TARGET    = 16'd3300;
  localparam logic [3:0]  DEFAULT_MAX_TRIES = 4'd8;
  localparam logic [3:0]  TRY_MAX           = 4'd15;
  localparam logic [5:0]  ATT_MAX           = 6'd63;

  typedef logic [5:0] att_t;

  // Item held in the search stage
  typedef struct packed {
    logic [1:0]       func;
    logic [1:0]       if_id;
    logic [15:0]      reading;
    logic             last;
    att_t [2:0]       start_att;
    logic [2:0]       mask;
  } item_t;

  // Result transaction payload
  typedef struct packed {
    att_t [2:0]       att;
    logic [1:0]       status;
    logic [3:0]       tries;
    logic [2:0]       ok_mask;
  } result_t;

endpackage

FILE: src/atts_zero_store.sv
module atts_zero_store #(
  parameter int NUM_SLOTS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [1:0]  func,
  input  logic [3:0]  slot,
  input  logic [15:0] reading,
  output logic [15:0] zero
);

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [15:0]          mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] filled;
  logic [15:0]          rd_data;
  logic                 rd_hit;
  logic                 in_range;
  logic [AW-1:0]        idx;

  assign in_range = {1'b0, slot} < 5'(NUM_SLOTS);
  assign idx      = slot[AW-1:0];

  // Zero readings; written on the accepting edge so the next item sees them
  always_ff @(posedge clk) begin
    if (accept && func == atts_pkg::FUNC_ZERO && in_range) begin
      mem[idx] <= reading;
    end
  end

  // Registered read, captured on the accepting edge
  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      rd_data <= mem[idx];
    end
  end

  // Per-entry valid bits; start empties the whole store
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      rd_hit <= 1'b0;
    end else if (accept) begin
      rd_hit <= in_range && filled[idx];
      if (func == atts_pkg::FUNC_START) begin
        filled <= '0;
      end else if (func == atts_pkg::FUNC_ZERO && in_range) begin
        filled[idx] <= 1'b1;
      end
    end
  end

  // Unwritten or out-of-range slot reads as zero
  assign zero = rd_hit ? rd_data : 16'd0;

endmodule

FILE: src/atts_search.sv
module atts_search (
  input  logic              clk,
  input  logic              rst,
  input  logic              s1_valid,
  input  atts_pkg::item_t   item,
  input  logic [15:0]       zero,
  input  logic [15:0]       target,
  input  logic [3:0]        max_tries,
  input  logic              out_stall,
  output logic              advance,
  output logic              out_valid,
  output atts_pkg::result_t res
);

  atts_pkg::att_t [2:0] cur_att;
  atts_pkg::att_t [2:0] low_bound;
  atts_pkg::att_t [2:0] high_bound;
  logic [2:0]           low_seen;
  logic [2:0]           high_seen;
  logic [2:0]           below_flags;
  logic [3:0]           try_count;
  logic [2:0]           active;

  atts_pkg::att_t [2:0] low_next;
  atts_pkg::att_t [2:0] high_next;
  atts_pkg::att_t [2:0] step_att;
  atts_pkg::att_t [2:0] conv_att;
  logic [2:0]           low_seen_next;
  logic [2:0]           high_seen_next;
  logic [2:0]           adjacent;
  logic [2:0]           ok;
  logic [2:0]           hit_vec;
  logic [2:0]           flags_now;
  logic [6:0]           mid_sum [3];
  logic [16:0]          limit;
  logic                 below_hit;
  logic                 is_result;
  logic                 fire;
  logic [3:0]           try_inc;
  atts_pkg::result_t    res_next;

  // Handshake of the search stage
  assign is_result = item.func == atts_pkg::FUNC_POWER && item.last;
  assign advance   = !is_result || !out_valid || !out_stall;
  assign fire      = s1_valid && advance;

  // reading - zero < target, done without sign as reading < zero + target
  assign limit     = {1'b0, zero} + {1'b0, target};
  assign below_hit = {1'b0, item.reading} < limit;

  // Bound update, convergence test and next attenuation per channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      hit_vec[c]        = below_hit && (item.if_id == 2'(c + 1));
      low_next[c]       = low_bound[c];
      high_next[c]      = high_bound[c];
      low_seen_next[c]  = low_seen[c];
      high_seen_next[c] = high_seen[c];
    end
    flags_now = below_flags | hit_vec;
    for (int c = 0; c < 3; c++) begin
      if (active[c]) begin
        if (flags_now[c]) begin
          high_next[c]      = cur_att[c];
          high_seen_next[c] = 1'b1;
        end else begin
          low_next[c]      = cur_att[c];
          low_seen_next[c] = 1'b1;
        end
      end
      adjacent[c] = {1'b0, high_next[c]} == ({1'b0, low_next[c]} + 7'd1);
      ok[c]       = !active[c] || (adjacent[c] && high_seen_next[c] && low_seen_next[c]);
      mid_sum[c]  = {1'b0, low_next[c]} + {1'b0, high_next[c]};
      if (!active[c]) begin
        step_att[c] = cur_att[c];
      end else if (!adjacent[c]) begin
        step_att[c] = mid_sum[c][6:1];
      end else if (!high_seen_next[c]) begin
        step_att[c] = high_next[c];
      end else begin
        step_att[c] = low_next[c];
      end
      conv_att[c] = active[c] ? low_next[c] : cur_att[c];
    end
  end

  // Result of a sweep-ending item
  always_comb begin
    try_inc = (try_count < atts_pkg::TRY_MAX) ? try_count + 4'd1 : try_count;
    res_next.ok_mask = ok;
    if (&ok) begin
      res_next.att    = conv_att;
      res_next.status = atts_pkg::STATUS_CONVERGED;
      res_next.tries  = try_count;
    end else begin
      res_next.att    = step_att;
      res_next.status = (try_inc >= max_tries) ? atts_pkg::STATUS_FAILED
                                               : atts_pkg::STATUS_STEPPING;
      res_next.tries  = try_inc;
    end
  end

  // Search state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_att     <= '0;
      low_bound   <= '0;
      high_bound  <= {3{atts_pkg::ATT_MAX}};
      low_seen    <= '0;
      high_seen   <= '0;
      below_flags <= '0;
      try_count   <= '0;
      active      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !(fire && is_result)) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        case (item.func)
          atts_pkg::FUNC_START: begin
            cur_att     <= item.start_att;
            low_bound   <= '0;
            high_bound  <= {3{atts_pkg::ATT_MAX}};
            low_seen    <= '0;
            high_seen   <= '0;
            below_flags <= '0;
            try_count   <= 4'd1;
            active      <= item.mask;
          end
          atts_pkg::FUNC_POWER: begin
            if (!item.last) begin
              below_flags <= flags_now;
            end else begin
              below_flags <= '0;
              low_bound   <= low_next;
              high_bound  <= high_next;
              low_seen    <= low_seen_next;
              high_seen   <= high_seen_next;
              cur_att     <= res_next.att;
              try_count   <= res_next.tries;
              out_valid   <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result payload, loaded with the valid
  always_ff @(posedge clk) begin
    if (fire && is_result) begin
      res <= res_next;
    end
  end

endmodule

FILE: src/attenuator_binary_search_core.sv
// Channel  Handshake            Payload
// in       in_valid / in_stall  func slot if_id reading last start_att_a..c channel_mask
// out      out_valid/ out_stall att_a att_b att_c status tries ok_mask
// cfg      cfg_write            cfg_index cfg_data (no read-back)
//
// One item per cycle while in_stall is low. An item reads the zero store on its
// accepting edge and is resolved in the search stage once it can advance; a
// sweep-ending item then loads the output register, which offers its result
// until the out channel takes it.
// Synchronous reset empties the zero store's valid bits at once; no sweep.
// A held result stalls the input only while the next sweep-ending item waits.
module attenuator_binary_search_core #(
  parameter int NUM_SLOTS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [3:0]  slot,
  input  logic [1:0]  if_id,
  input  logic [15:0] reading,
  input  logic        last,
  input  logic [5:0]  start_att_a,
  input  logic [5:0]  start_att_b,
  input  logic [5:0]  start_att_c,
  input  logic [2:0]  channel_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  att_a,
  output logic [5:0]  att_b,
  output logic [5:0]  att_c,
  output logic [1:0]  status,
  output logic [3:0]  tries,
  output logic [2:0]  ok_mask,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]       target_level;
  logic [3:0]        max_tries;
  logic [15:0]       target_eff;
  logic              accept;
  logic              s1_valid;
  logic              advance;
  atts_pkg::item_t   s1_item;
  logic [15:0]       zero;
  atts_pkg::result_t res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_level <= atts_pkg::DEFAULT_TARGET;
      max_tries    <= atts_pkg::DEFAULT_MAX_TRIES;
    end else if (cfg_write) begin
      case (cfg_index)
        atts_pkg::CFG_TARGET_LEVEL: target_level <= cfg_data;
        atts_pkg::CFG_MAX_TRIES:    max_tries    <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // A target of zero falls back to the default
  assign target_eff = (target_level != 16'd0) ? target_level : atts_pkg::DEFAULT_TARGET;

  // Input handshake
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.func      <= func;
      s1_item.if_id     <= if_id;
      s1_item.reading   <= reading;
      s1_item.last      <= last;
      s1_item.start_att <= {start_att_c, start_att_b, start_att_a};
      s1_item.mask      <= channel_mask;
    end
  end

  atts_zero_store #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_zero_store (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .func    (func),
    .slot    (slot),
    .reading (reading),
    .zero    (zero)
  );

  atts_search u_search (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .item      (s1_item),
    .zero      (zero),
    .target    (target_eff),
    .max_tries (max_tries),
    .out_stall (out_stall),
    .advance   (advance),
    .out_valid (out_valid),
    .res       (res)
  );

  assign att_a   = res.att[0];
  assign att_b   = res.att[1];
  assign att_c   = res.att[2];
  assign status  = res.status;
  assign tries   = res.tries;
  assign ok_mask = res.ok_mask;

  // Input is held back only by a search-stage item that cannot move
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty search stage");

  // An accepted item always lands in the search stage
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted item lost");

  // A sweep-ending item that moves on produces a result
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && s1_item.func == atts_pkg::FUNC_POWER && s1_item.last)
      |=> out_valid)
    else $error("sweep end without result");

  // Converged is reported only with every channel settled
  a_converged_all_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == atts_pkg::STATUS_CONVERGED) |-> ok_mask == 3'b111)
    else $error("converged with unsettled channel");

endmodule
